/* src/aepq_pkg.sv */
// shared types and constants for the active/expired priority queue block
// no dependencies
package aepq_pkg;

   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   localparam int PRIO_W      = 3;
   localparam int LEVEL_OUT_W = 2;

   typedef struct packed {
      logic                   found;
      logic [LEVEL_OUT_W-1:0] level_used;
      logic                   to_expired;
      logic                   banks_swapped;
      logic                   overflow;
   } flags_type;

endpackage

/* src/aepq_ram.sv */
// generic single-port ram with registered read data
// no dependencies
module aepq_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/aepq_qstate.sv */
// per-fifo head and fill count, active bank flag, level selection and ram addressing
// depends on aepq_pkg
module aepq_qstate #(
   parameter int LEVELS = 4,
   parameter int FIFO_DEPTH = 16,
   localparam int QN = 2 * LEVELS,
   localparam int AW = $clog2(QN * FIFO_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic                             kind,
   input  logic [aepq_pkg::PRIO_W-1:0]      static_prio,
   input  logic signed [aepq_pkg::PRIO_W-1:0] dyn_prio,
   output aepq_pkg::flags_type              flags,
   output logic                             mem_we,
   output logic                             mem_re,
   output logic [AW-1:0]                    mem_addr
);

   localparam int QW = $clog2(QN);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic [PW-1:0] head_ff  [QN];
   logic [CW-1:0] count_ff [QN];
   logic          bank_ff;

   logic [LEVELS-1:0] ne0;
   logic [LEVELS-1:0] ne1;
   logic [LEVELS-1:0] ne_act;
   logic [LEVELS-1:0] ne_exp;
   logic              expired;
   logic [2:0]        raw_lvl;
   logic [LW-1:0]     enq_level;
   logic              op_bank;
   logic [LW-1:0]     op_level;
   logic [QW-1:0]     q;
   logic [PW-1:0]     cur_head;
   logic [CW-1:0]     cur_count;
   logic              full;
   logic [CW:0]       wsum;
   logic [PW-1:0]     wslot;
   logic [PW-1:0]     head_in;
   logic [CW-1:0]     count_in;
   logic              upd;

   function automatic logic [LW-1:0] top_level(input logic [LEVELS-1:0] v);
      logic [LW-1:0] r;
      r = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (v[l]) begin
            r = LW'(l);
         end
      end
      return r;
   endfunction

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         ne0[l] = (count_ff[l] != '0);
         ne1[l] = (count_ff[LEVELS + l] != '0);
      end
   end

   assign ne_act  = bank_ff ? ne1 : ne0;
   assign ne_exp  = bank_ff ? ne0 : ne1;
   assign expired = dyn_prio[aepq_pkg::PRIO_W-1];

   always_comb begin
      if (expired) begin
         raw_lvl = (static_prio == '0) ? 3'd0 : static_prio - 3'd1;
      end else begin
         raw_lvl = {1'b0, dyn_prio[1:0]};
      end
      enq_level = (int'(raw_lvl) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(raw_lvl);
   end

   always_comb begin
      flags    = '0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      upd      = 1'b0;
      op_bank  = bank_ff;
      op_level = '0;

      if (kind == aepq_pkg::KIND_ENQ) begin
         op_bank  = bank_ff ^ expired;
         op_level = enq_level;
      end else if (|ne_act) begin
         op_level    = top_level(ne_act);
         flags.found = 1'b1;
      end else begin
         op_bank             = ~bank_ff;
         flags.banks_swapped = 1'b1;
         if (|ne_exp) begin
            op_level    = top_level(ne_exp);
            flags.found = 1'b1;
         end
      end

      q         = op_bank ? (QW'(LEVELS) + QW'(op_level)) : QW'(op_level);
      cur_head  = head_ff[q];
      cur_count = count_ff[q];
      full      = (cur_count == CW'(FIFO_DEPTH));
      wsum      = (CW+1)'(cur_head) + (CW+1)'(cur_count);
      wslot     = (wsum >= (CW+1)'(FIFO_DEPTH)) ? PW'(wsum - (CW+1)'(FIFO_DEPTH)) : PW'(wsum);
      head_in   = cur_head;
      count_in  = cur_count;

      if (kind == aepq_pkg::KIND_ENQ) begin
         flags.level_used = aepq_pkg::LEVEL_OUT_W'(enq_level);
         flags.to_expired = expired;
         flags.overflow   = full;
         mem_we           = go && !full;
         upd              = !full;
         count_in         = cur_count + 1'b1;
         mem_addr         = AW'(q) * AW'(FIFO_DEPTH) + AW'(wslot);
      end else begin
         if (flags.found) begin
            flags.level_used = aepq_pkg::LEVEL_OUT_W'(op_level);
         end
         mem_re   = go && flags.found;
         upd      = flags.found;
         head_in  = (cur_head == PW'(FIFO_DEPTH - 1)) ? '0 : cur_head + 1'b1;
         count_in = cur_count - 1'b1;
         mem_addr = AW'(q) * AW'(FIFO_DEPTH) + AW'(cur_head);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         for (int i = 0; i < QN; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (go) begin
         if (flags.banks_swapped) begin
            bank_ff <= ~bank_ff;
         end
         if (upd) begin
            head_ff[q]  <= head_in;
            count_ff[q] <= count_in;
         end
      end
   end

endmodule

/* src/active_expired_priority_queues.sv */
// top level: request decode, response registers, task id ram and queue state
// depends on aepq_pkg, aepq_ram, aepq_qstate
//
// Multilevel ready queue with an active and an expired bank of fifos, one fifo per
// level in each bank, all task ids held in a single ram with registered read data.
// A request is taken when start is high and busy is low. An enqueue updates
// the fifo pointers and writes the ram in the cycle it is taken and its response
// strobes on rsp_valid in the next cycle, while a new request can already be taken,
// so enqueues run at one per cycle. A dequeue holds busy through the extra S_READ
// state to wait for the ram read, and its response strobes in the cycle busy
// drops. rsp_valid lasts exactly one cycle and cannot be held off; the receiver
// must take every response when it appears. No clearing pass is needed after reset.
module active_expired_priority_queues #(
   parameter int LEVELS = 4,
   parameter int FIFO_DEPTH = 16,
   parameter int TASK_COUNT = 64,
   localparam int TW = $clog2(TASK_COUNT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [TW-1:0]                       req_task_id,
   input  logic [aepq_pkg::PRIO_W-1:0]         req_static_prio,
   input  logic signed [aepq_pkg::PRIO_W-1:0]  req_dyn_prio,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [TW-1:0]                       rsp_chosen_task,
   output logic [aepq_pkg::LEVEL_OUT_W-1:0]    rsp_level_used,
   output logic                                rsp_to_expired,
   output logic                                rsp_banks_swapped,
   output logic                                rsp_overflow
);

   localparam int QN    = 2 * LEVELS;
   localparam int DEPTH = QN * FIFO_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type           state_ff;
   logic                rsp_valid_ff;
   aepq_pkg::flags_type flags_ff;
   logic [TW-1:0]       task_ff;

   aepq_pkg::flags_type flags;
   logic                go;
   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_addr;
   logic [TW-1:0]       rd_data;

   assign busy = (state_ff == S_READ);
   assign go   = start && !busy;

   aepq_qstate #(
      .LEVELS     (LEVELS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_qstate (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .kind        (req_kind),
      .static_prio (req_static_prio),
      .dyn_prio    (req_dyn_prio),
      .flags       (flags),
      .mem_we      (mem_we),
      .mem_re      (mem_re),
      .mem_addr    (mem_addr)
   );

   aepq_ram #(
      .WIDTH (TW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (req_task_id),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (go) begin
                  flags_ff <= flags;
                  task_ff  <= '0;
                  if (req_kind == aepq_pkg::KIND_DEQ) begin
                     state_ff <= S_READ;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_READ: begin
               rsp_valid_ff <= 1'b1;
               task_ff      <= flags_ff.found ? rd_data : '0;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = flags_ff.found;
   assign rsp_chosen_task   = task_ff;
   assign rsp_level_used    = flags_ff.level_used;
   assign rsp_to_expired    = flags_ff.to_expired;
   assign rsp_banks_swapped = flags_ff.banks_swapped;
   assign rsp_overflow      = flags_ff.overflow;

`ifndef ASSERT_OFF
   a_read_then_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("dequeue read not followed by response");

   a_enq_rsp: assert property (@(posedge clock) disable iff (reset)
      (go && req_kind == aepq_pkg::KIND_ENQ) |=> rsp_valid && !rsp_found && !rsp_banks_swapped)
      else $error("enqueue response missing or malformed");

   a_deq_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> !rsp_to_expired && !rsp_overflow)
      else $error("dequeue response carries enqueue flags");

   a_empty_task: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_chosen_task == '0)
      else $error("nonzero task id without a found task");
`endif

endmodule
